>>> design/lgrs_pkg.sv
package lgrs_pkg;

  localparam int MAX_COLS = 64;
  localparam int WIDTH_BITS = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

  // Register word index as decoded from paddr[2]
  localparam logic REG_GRID_WIDTH = 1'b0;
  localparam logic [WIDTH_BITS-1:0] GRID_WIDTH_RESET = WIDTH_BITS'(MAX_COLS);

  typedef logic [MAX_COLS-1:0] row_t;

  typedef struct packed {
    row_t row;
    logic last;
  } res_t;

  typedef struct packed {
    logic push_first;
    logic push_second;
    res_t first;
    res_t second;
  } push_t;

  // Columns at or above the width read as dead; widths above MAX_COLS saturate.
  function automatic row_t col_mask(input logic [WIDTH_BITS-1:0] width);
    row_t m;
    for (int j = 0; j < MAX_COLS; j++) begin
      m[j] = (WIDTH_BITS'(j) < width);
    end
    return m;
  endfunction

  // B3/S23 on one row, given the rows above and below; edges are dead.
  function automatic row_t life_row(input row_t up, input row_t mid, input row_t down,
                                    input row_t m);
    row_t u;
    row_t c;
    row_t d;
    row_t res;
    logic [3:0] cnt;
    u = up & m;
    c = mid & m;
    d = down & m;
    for (int j = 0; j < MAX_COLS; j++) begin
      cnt = 4'(u[j]) + 4'(d[j]);
      if (j > 0) begin
        cnt = cnt + 4'(u[j-1]) + 4'(c[j-1]) + 4'(d[j-1]);
      end
      if (j < MAX_COLS - 1) begin
        cnt = cnt + 4'(u[j+1]) + 4'(c[j+1]) + 4'(d[j+1]);
      end
      res[j] = c[j] ? ((cnt == 4'd2) || (cnt == 4'd3)) : (cnt == 4'd3);
    end
    return res & m;
  endfunction

endpackage

>>> design/lgrs_cfg.sv
module lgrs_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output lgrs_pkg::row_t                     mask
);

  logic [lgrs_pkg::WIDTH_BITS-1:0] grid_width;
  logic                            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == lgrs_pkg::REG_GRID_WIDTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= lgrs_pkg::GRID_WIDTH_RESET;
    end else if (wr_en) begin
      grid_width <= pwdata[lgrs_pkg::WIDTH_BITS-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == lgrs_pkg::REG_GRID_WIDTH) begin
      prdata = 32'(grid_width);
    end else begin
      prdata = '0;
    end
  end

  assign mask = lgrs_pkg::col_mask(grid_width);

endmodule

>>> design/lgrs_core.sv
module lgrs_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lgrs_pkg::row_t      row_cells,
  input  logic                last_row,
  input  lgrs_pkg::row_t      mask,
  input  logic                room,
  output lgrs_pkg::push_t     push
);

  logic           in_valid_q;
  lgrs_pkg::row_t in_row_q;
  logic           in_last_q;
  lgrs_pkg::row_t row_above;
  lgrs_pkg::row_t row_pending;
  logic           rows_held;

  logic           consume;
  lgrs_pkg::row_t row_now;
  lgrs_pkg::row_t above_next;
  lgrs_pkg::res_t res_pend;
  lgrs_pkg::res_t res_last;

  assign consume  = in_valid_q && room;
  assign in_stall = in_valid_q && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_row_q  <= row_cells;
      in_last_q <= last_row;
    end
  end

  always_comb begin
    row_now       = in_row_q & mask;
    above_next    = rows_held ? row_pending : '0;
    res_pend.row  = lgrs_pkg::life_row(row_above, row_pending, row_now, mask);
    res_pend.last = 1'b0;
    res_last.row  = lgrs_pkg::life_row(above_next, row_now, '0, mask);
    res_last.last = 1'b1;

    push.push_first  = consume && (rows_held || in_last_q);
    push.push_second = consume && rows_held && in_last_q;
    push.first       = rows_held ? res_pend : res_last;
    push.second      = res_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_held <= 1'b0;
    end else if (consume) begin
      rows_held <= !in_last_q;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      row_above   <= in_last_q ? '0 : above_next;
      row_pending <= in_last_q ? '0 : row_now;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    consume && in_last_q |=> !rows_held)
    else $error("pending row still held after last row");
  a_first_row_silent: assert property (@(posedge clk) disable iff (rst)
    consume && !rows_held && !in_last_q |-> !push.push_first)
    else $error("result released for first row of a grid");
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.push_second |-> push.push_first && push.second.last && !push.first.last)
    else $error("second result without proper first result");

endmodule

>>> design/lgrs_outq.sv
module lgrs_outq (
  input  logic             clk,
  input  logic             rst,
  input  lgrs_pkg::push_t  push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output lgrs_pkg::row_t   next_row,
  output logic             last_out
);

  lgrs_pkg::res_t                        slots [lgrs_pkg::QUEUE_DEPTH];
  logic [lgrs_pkg::QUEUE_PTR_BITS-1:0]   head;
  logic [lgrs_pkg::QUEUE_PTR_BITS-1:0]   tail;
  logic [lgrs_pkg::QUEUE_CNT_BITS-1:0]   count;
  logic [lgrs_pkg::QUEUE_CNT_BITS-1:0]   count_next;
  logic [lgrs_pkg::QUEUE_PTR_BITS-1:0]   tail_next;
  logic                                  pop;

  // Two free slots cover the worst case of one transaction.
  assign room      = (count <= lgrs_pkg::QUEUE_CNT_BITS'(lgrs_pkg::QUEUE_DEPTH - 2));
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign next_row  = slots[head].row;
  assign last_out  = slots[head].last;

  always_comb begin
    count_next = count + lgrs_pkg::QUEUE_CNT_BITS'(push.push_first)
               + lgrs_pkg::QUEUE_CNT_BITS'(push.push_second)
               - lgrs_pkg::QUEUE_CNT_BITS'(pop);
    tail_next  = tail + lgrs_pkg::QUEUE_PTR_BITS'(push.push_first)
               + lgrs_pkg::QUEUE_PTR_BITS'(push.push_second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail_next;
      count <= count_next;
      if (pop) begin
        head <= head + lgrs_pkg::QUEUE_PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.push_first) begin
      slots[tail] <= push.first;
    end
    if (push.push_second) begin
      slots[tail + lgrs_pkg::QUEUE_PTR_BITS'(1)] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= lgrs_pkg::QUEUE_CNT_BITS'(lgrs_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.push_first |-> $past(room) || room)
    else $error("push into full result queue");
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (count == '0) || (count == lgrs_pkg::QUEUE_CNT_BITS'(lgrs_pkg::QUEUE_DEPTH))
    || (tail != head))
    else $error("queue pointers disagree with count");

endmodule

>>> design/life_generation_row_stream_unit.sv
// One generation of Life (B3/S23) on a bounded, non-wrapping grid up to 64
// columns wide, streamed one row per transaction. Bit j of row_cells is
// column j; columns at or above grid_width (register at byte address 0,
// reset 64, values above 64 act as 64) are dead and come out as zero. The
// first row of a grid yields nothing unless last_row is set; each later row
// releases the next generation of the row above it, and a row with last_row
// set also releases its own result with last_out set, after which a new grid
// may begin. Rows are taken one per cycle while in_stall is low: an input
// register feeds the neighbor-count logic, which writes into a four-entry
// result queue, and a last row pushes a second entry for its own result.
// Input stall rises only when that queue has fewer than two free entries.
// Change grid_width only between transactions, with every result already taken.
module life_generation_row_stream_unit (
  input  logic                clk,
  input  logic                rst,
  // row input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [63:0]         row_cells,
  input  logic                last_row,
  // result output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         next_row,
  output logic                last_out,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  lgrs_pkg::row_t  mask;
  lgrs_pkg::push_t push;
  logic            room;

  // Hold the width register and derive the live-column mask.
  lgrs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mask    (mask)
  );

  // Register the row, keep the two previous rows, compute up to two results.
  lgrs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .row_cells (row_cells),
    .last_row  (last_row),
    .mask      (mask),
    .room      (room),
    .push      (push)
  );

  // Queue results so the input side keeps moving while the output stalls.
  lgrs_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .next_row  (next_row),
    .last_out  (last_out)
  );

endmodule

>>> dv/life_generation_row_stream_unit_tb.sv
module life_generation_row_stream_unit_tb;

  typedef lgrs_pkg::row_t row_t;
  typedef lgrs_pkg::res_t res_t;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 10;
  // Input register and result queue, plus margin for a first row that yields nothing
  localparam int SETTLE_CYCLES  = 8;
  localparam int QUIET_LIMIT    = 2000;
  localparam int PHASE_COUNT    = 8;
  localparam int ROWS_PER_PHASE = 179;

  localparam logic [2:0] GRID_WIDTH_ADDR = {lgrs_pkg::REG_GRID_WIDTH, 2'b00};
  // Second word of the register map: nothing lives there
  localparam logic [2:0] UNMAPPED_ADDR   = {~lgrs_pkg::REG_GRID_WIDTH, 2'b00};

  localparam logic [6:0] WIDTH_NONE = 7'd0;
  localparam logic [6:0] WIDTH_ONE  = 7'd1;
  localparam logic [6:0] WIDTH_FULL = lgrs_pkg::GRID_WIDTH_RESET;
  localparam logic [6:0] WIDTH_TOP  = 7'd127;

  typedef struct packed {
    row_t cells;
    logic is_last;
  } grid_row_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [63:0] row_cells = '0;
  logic        last_row  = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] next_row;
  logic        last_out;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Rows waiting to be driven, and next-generation rows still owed by the block
  grid_row_t rows_to_send[$];
  res_t      next_rows_due[$];
  grid_row_t next_item;

  // Shadow of the block: width register and the two rows it holds
  logic [6:0] grid_width_q = WIDTH_FULL;
  row_t       above_row    = '0;
  row_t       pending_row  = '0;
  logic       row_held     = 1'b0;

  int send_gap_pct   = 0;
  int stall_pct      = 0;
  int grid_rows_left = 0;
  int quiet_cycles   = 0;
  int mismatches     = 0;
  int rows_accepted  = 0;
  int grids_closed   = 0;
  int results_seen   = 0;
  int width_writes   = 0;

  always #CLK_HALF clk = ~clk;

  life_generation_row_stream_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .row_cells (row_cells),
    .last_row  (last_row),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .next_row  (next_row),
    .last_out  (last_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Columns below the width are live-capable; widths past 64 saturate
  function automatic row_t width_mask(input logic [6:0] width);
    row_t m;
    int   cols;
    cols = (width > 7'd64) ? 64 : int'(width);
    for (int j = 0; j < 64; j++) begin
      m[j] = (j < cols);
    end
    return m;
  endfunction

  // B3/S23 for the middle row; anything off the grid is dead
  function automatic row_t next_gen(input row_t up, input row_t mid, input row_t down,
                                    input row_t m);
    row_t u;
    row_t c;
    row_t d;
    row_t gen;
    int   live;
    int   col;
    u = up & m;
    c = mid & m;
    d = down & m;
    gen = '0;
    for (int j = 0; j < 64; j++) begin
      live = 0;
      for (int k = -1; k <= 1; k++) begin
        col = j + k;
        if (col >= 0 && col < 64) begin
          live += int'(u[col]) + int'(d[col]);
          if (k != 0) live += int'(c[col]);
        end
      end
      gen[j] = c[j] ? (live == 2 || live == 3) : (live == 3);
    end
    return gen & m;
  endfunction

  // Advance the shadow by one accepted row and queue the rows it releases
  task automatic advance_generation(input row_t cells, input logic is_last);
    row_t m;
    row_t row_in;
    res_t owed;
    m = width_mask(grid_width_q);
    row_in = cells & m;
    if (row_held) begin
      owed.row  = next_gen(above_row, pending_row, row_in, m);
      owed.last = 1'b0;
      next_rows_due.insert(next_rows_due.size(), owed);
      above_row = pending_row;
    end else begin
      above_row = '0;
    end
    pending_row = row_in;
    row_held = 1'b1;
    if (is_last) begin
      owed.row  = next_gen(above_row, pending_row, '0, m);
      owed.last = 1'b1;
      next_rows_due.insert(next_rows_due.size(), owed);
      above_row = '0;
      pending_row = '0;
      row_held = 1'b0;
      grids_closed += 1;
    end
  endtask

  task automatic check_result(input row_t got_row, input logic got_last);
    res_t due;
    results_seen += 1;
    if (next_rows_due.size() == 0) begin
      $display("%0t: result expected none actual next_row %h last_out %b",
               $time, got_row, got_last);
      mismatches += 1;
    end else begin
      due = next_rows_due.pop_front();
      if (got_row !== due.row) begin
        $display("%0t: next_row expected %h actual %h", $time, due.row, got_row);
        mismatches += 1;
      end
      if (got_last !== due.last) begin
        $display("%0t: last_out expected %b actual %b", $time, due.last, got_last);
        mismatches += 1;
      end
    end
  endtask

  task automatic add_row(input row_t cells, input logic is_last);
    grid_row_t item;
    item.cells   = cells;
    item.is_last = is_last;
    rows_to_send.insert(rows_to_send.size(), item);
  endtask

  // Mix of dense, sparse, solid and small-pattern rows
  function automatic row_t random_row();
    row_t a;
    row_t b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0, 1: return a;
      2:    return a & b;
      3:    return a | b;
      4:    return $urandom_range(1) ? '1 : '0;
      default: return row_t'($urandom_range(1, 7)) << $urandom_range(0, 63);
    endcase
  endfunction

  // Append one row of a random-length grid; force_close ends the open grid
  task automatic add_random_row(input logic force_close);
    logic is_last;
    if (grid_rows_left == 0) begin
      case ($urandom_range(9))
        0:       grid_rows_left = 1;
        7, 8:    grid_rows_left = $urandom_range(7, 16);
        9:       grid_rows_left = $urandom_range(17, 40);
        default: grid_rows_left = $urandom_range(2, 6);
      endcase
    end
    is_last = (grid_rows_left == 1) || force_close;
    grid_rows_left = is_last ? 0 : grid_rows_left - 1;
    add_row(random_row(), is_last);
  endtask

  // Hold until every row is taken and every owed result has come back
  task automatic drain_and_settle();
    while (rows_to_send.size() != 0 || in_valid || next_rows_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value on the pready edge
  task automatic write_reg(input logic [2:0] addr, input logic [6:0] value);
    logic [31:0] word;
    word = $urandom;
    word[6:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == GRID_WIDTH_ADDR) grid_width_q = value;
    width_writes += 1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Row driver: take the accepted transaction into the shadow, then offer the
  // next row or go idle. Valid only drops once the current row is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_generation(row_cells, last_row);
        rows_accepted += 1;
      end
      if (!in_valid || !in_stall) begin
        if (rows_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_item = rows_to_send.pop_front();
          in_valid  <= 1'b1;
          row_cells <= next_item.cells;
          last_row  <= next_item.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: stall at random and compare every accepted transaction
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst && out_valid && !out_stall) check_result(next_row, last_out);
  end

  // Watchdog: any handshake on any port clears the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT - 1) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [6:0] width_sel;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed grids at the reset width, no idling
    add_row('1, 1'b1);                                  // one-row grid, all live
    add_row('0, 1'b1);                                  // one-row grid, all dead
    add_row('0, 1'b0);                                  // blinker
    add_row(64'h0000_0000_0000_1C00, 1'b0);
    add_row('0, 1'b1);
    add_row(64'hC000_0000_0000_0003, 1'b0);             // blocks on both edge columns
    add_row(64'hC000_0000_0000_0003, 1'b1);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);             // checkerboard into a solid row
    add_row(64'h5555_5555_5555_5555, 1'b0);
    add_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_row('1, 1'b1);
    add_row(64'h0000_0000_0000_0002, 1'b0);             // glider against column 0
    add_row(64'h0000_0000_0000_0004, 1'b0);
    add_row(64'h0000_0000_0000_0007, 1'b1);
    add_row('1, 1'b0);                                  // solid square: only corners live
    add_row('1, 1'b0);
    add_row('1, 1'b1);

    // Random grids; a grid may stay open across a width change
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_and_settle();
      case (p)
        0:       width_sel = WIDTH_ONE;
        1:       width_sel = WIDTH_NONE;
        2:       width_sel = WIDTH_TOP;
        3:       width_sel = 7'd63;
        4:       width_sel = 7'd65;
        5:       width_sel = 7'($urandom_range(2, 62));
        6:       width_sel = WIDTH_FULL;
        default: width_sel = 7'($urandom_range(0, 127));
      endcase
      write_reg(GRID_WIDTH_ADDR, width_sel);
      // A write to the empty word must leave the width alone
      if (p == 2) write_reg(UNMAPPED_ADDR, 7'($urandom));
      case (p % 4)
        0:       begin send_gap_pct = 0;  stall_pct = 0;  end
        1:       begin send_gap_pct = 80; stall_pct = 0;  end
        2:       begin send_gap_pct = 0;  stall_pct = 80; end
        default: begin send_gap_pct = 29; stall_pct = 29; end
      endcase
      for (int k = 0; k < ROWS_PER_PHASE; k++)
        add_random_row(p == PHASE_COUNT - 1 && k == ROWS_PER_PHASE - 1);
    end

    drain_and_settle();
    $display("Streamed %0d rows in %0d grids over %0d register writes.",
             rows_accepted, grids_closed, width_writes);
    $display("Checked %0d result rows, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> life_generation_row_stream_unit.f
design/lgrs_pkg.sv
design/lgrs_cfg.sv
design/lgrs_core.sv
design/lgrs_outq.sv
design/life_generation_row_stream_unit.sv
dv/life_generation_row_stream_unit_tb.sv
